### rtl/sparse_lower_triangular_solve_core_assert.svh
// assertion macros used by the checker file
`ifndef SPARSE_LOWER_TRIANGULAR_SOLVE_CORE_ASSERT_SVH
`define SPARSE_LOWER_TRIANGULAR_SOLVE_CORE_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define SLTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define SLTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/slts_pkg.sv
// ----------------------------------------------------------------------------
// slts_pkg
// shared constants and types of the sparse triangular solve core
// ----------------------------------------------------------------------------
package slts_pkg;
    localparam int MaxRows = 1024;
    localparam int RowW    = $clog2(MaxRows);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_COLUMN  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // apb register byte addresses
    localparam logic [2:0] ADDR_ROW_COUNT = 3'd0;

    typedef struct packed {
        logic        start;
        logic [63:0] num;   // magnitude of dividend
        logic [31:0] den;   // magnitude of divisor
    } t_div_req;
endpackage

### rtl/sparse_lower_triangular_solve_core.sv
// ----------------------------------------------------------------------------
// sparse_lower_triangular_solve_core
// forward substitution over a row-compressed lower-triangular matrix
// ----------------------------------------------------------------------------
// One nonzero per input transaction. A well-formed off-diagonal entry passes
// through accept, solution memory read, multiply, round/saturate. A diagonal
// entry, nonzero and in range, runs the bit-serial divider, 64 steps, then
// presents the solved unknown on the output register; the next transaction is
// taken once the result has left. Numbers are signed Q16.16 with saturation.
module sparse_lower_triangular_solve_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: matrix_start, row_first, row_last, column[9:0],
    //        entry_value[31:0], rhs_value[31:0], zero fill to 80 bits
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: row_index[9:0], solution_value[31:0], status[1:0], zero fill
    output logic [47:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [10:0] r_row_count;
    logic [10:0] r_cur_row;
    logic [31:0] r_acc;
    logic [1:0]  r_fault;
    logic [9:0]  r_col;
    logic [31:0] r_entry;
    logic        r_last;
    logic [31:0] r_xval;
    logic signed [63:0] r_prod;
    logic        r_neg;
    logic [9:0]  r_oidx;
    logic [31:0] r_oval;
    logic [1:0]  r_ostat;
    logic [31:0] r_mem [slts_pkg::MaxRows];

    // input field unpack
    logic        w_start, w_first, w_last;
    logic [9:0]  w_col;
    logic [31:0] w_entry, w_rhs;
    assign w_start = s_axis_tdata[0];
    assign w_first = s_axis_tdata[1];
    assign w_last  = s_axis_tdata[2];
    assign w_col   = s_axis_tdata[12:3];
    assign w_entry = s_axis_tdata[44:13];
    assign w_rhs   = s_axis_tdata[76:45];

    logic w_in_acc, w_cfg_wr;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == slts_pkg::ADDR_ROW_COUNT);
    assign prdata   = (paddr == slts_pkg::ADDR_ROW_COUNT) ? {21'd0, r_row_count} : 32'd0;

    // row state as seen by the entry being accepted
    logic [10:0] w_row;
    logic [31:0] w_acc0;
    logic [1:0]  w_fault0, w_fault1;
    logic        w_ovf;
    logic [10:0] w_limit;
    assign w_row    = w_start ? 11'd0 : r_cur_row;
    assign w_acc0   = (w_start || w_first) ? w_rhs : r_acc;
    assign w_fault0 = (w_start || w_first) ? slts_pkg::ST_OK : r_fault;
    assign w_limit  = (r_row_count > 11'(slts_pkg::MaxRows)) ? 11'(slts_pkg::MaxRows)
                                                             : r_row_count;
    assign w_ovf    = (w_row >= w_limit);
    always_comb begin
        w_fault1 = w_fault0;
        if (w_fault1 == slts_pkg::ST_OK) begin
            if (w_ovf)
                w_fault1 = slts_pkg::ST_OVERFLOW;
            else if (!w_last && ({1'b0, w_col} >= w_row))
                w_fault1 = slts_pkg::ST_COLUMN;
            else if (w_last && ({1'b0, w_col} != w_row))
                w_fault1 = slts_pkg::ST_COLUMN;
        end
    end

    // multiply-accumulate datapath
    logic signed [63:0] w_diff;
    logic signed [63:0] w_rnd;
    logic signed [47:0] w_flr;
    logic [31:0] w_sat;
    assign w_diff = ({{32{r_acc[31]}}, r_acc} <<< 16) - r_prod;
    assign w_rnd  = w_diff + 64'sd32768;
    assign w_flr  = w_rnd[63:16];
    assign w_sat  = (w_flr > 48'sh7FFFFFFF) ? 32'h7FFFFFFF :
                    (w_flr < -48'sh80000000) ? 32'h80000000 : w_flr[31:0];

    // divider
    slts_pkg::t_div_req w_dreq;
    logic        w_ddone;
    logic [63:0] w_dquot;
    logic [63:0] w_num_mag;
    logic [31:0] w_den_mag;
    logic [64:0] w_qr;
    logic [31:0] w_div_res;
    assign w_num_mag = r_acc[31] ? 64'(-{{16{r_acc[31]}}, r_acc, 16'd0})
                                 : {16'd0, r_acc, 16'd0};
    assign w_den_mag = r_entry[31] ? -r_entry : r_entry;
    // rounding by adding half the divisor to the dividend
    assign w_dreq.start = (r_state == S_DIV);
    assign w_dreq.num   = w_num_mag + {33'd0, w_den_mag[31:1]};
    assign w_dreq.den   = w_den_mag;
    assign w_qr = {1'b0, w_dquot};
    always_comb begin
        if (r_neg)
            w_div_res = (w_qr > 65'h80000000) ? 32'h80000000 : 32'(-w_dquot[31:0]);
        else
            w_div_res = (w_qr > 65'h7FFFFFFF) ? 32'h7FFFFFFF : w_dquot[31:0];
    end

    slts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_done  (w_ddone),
        .o_quot  (w_dquot)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_acc) begin
                if (w_ovf)
                    n_state = w_last ? S_FIN : S_IDLE;
                else if (w_last)
                    n_state = (w_entry == 32'd0) ? S_FIN : S_DIV;
                else if (w_fault1 != w_fault0 && w_fault0 == slts_pkg::ST_OK)
                    n_state = S_IDLE;
                else if ({1'b0, w_col} >= w_row)
                    n_state = S_IDLE;
                else
                    n_state = S_READ;
            end
            S_READ:  n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = S_IDLE;
            S_DIV:   n_state = S_FIN;
            S_FIN:   if (r_last && r_entry != 32'd0 && !w_ddone && r_fault != slts_pkg::ST_OVERFLOW)
                         n_state = S_FIN;
                     else
                         n_state = S_OUT;
            S_OUT:   if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_count <= 11'd1024;
            r_cur_row   <= '0;
            r_acc       <= '0;
            r_fault     <= slts_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) r_row_count <= pwdata[10:0];
            if (w_in_acc) begin
                r_cur_row <= w_row;
                r_acc     <= w_acc0;
                r_fault   <= w_fault1;
            end
            if (r_state == S_ACC) r_acc <= w_sat;
            if (r_state == S_FIN && n_state == S_OUT) begin
                // unknown goes to the output register; advance the row
                if (r_cur_row != 11'd2047) r_cur_row <= r_cur_row + 11'd1;
                r_acc   <= '0;
                r_fault <= slts_pkg::ST_OK;
            end
        end
    end

    // payload registers
    logic [31:0] w_x;
    always_comb begin
        if (r_fault == slts_pkg::ST_OVERFLOW)
            w_x = '0;
        else if (r_entry == 32'd0)
            w_x = r_acc[31] ? 32'h80000000 : ((r_acc != 0) ? 32'h7FFFFFFF : 32'd0);
        else
            w_x = w_div_res;
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_col   <= w_col;
            r_entry <= w_entry;
            r_last  <= w_last;
            r_neg   <= w_acc0[31] ^ w_entry[31];
        end
        if (r_state == S_READ) r_xval <= r_mem[r_col];
        if (r_state == S_MUL)  r_prod <= $signed(r_entry) * $signed(r_xval);
        if (r_state == S_DIV)  r_neg <= (r_acc[31] && r_acc != 0) ^ r_entry[31];
        if (r_state == S_FIN && n_state == S_OUT) begin
            r_oidx  <= (r_cur_row > 11'd1023) ? 10'd1023 : r_cur_row[9:0];
            r_oval  <= w_x;
            r_ostat <= (r_fault == slts_pkg::ST_OK && r_entry == 32'd0 &&
                        r_fault != slts_pkg::ST_OVERFLOW) ? slts_pkg::ST_ZERO : r_fault;
            if (r_fault != slts_pkg::ST_OVERFLOW && r_cur_row < 11'(slts_pkg::MaxRows))
                r_mem[r_cur_row[slts_pkg::RowW-1:0]] <= w_x;
        end
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {4'd0, r_ostat, r_oval, r_oidx};
endmodule

### rtl/slts_div.sv
// ----------------------------------------------------------------------------
// slts_div
// restoring unsigned divider, one quotient bit per cycle, 64 by 32 bits
// ----------------------------------------------------------------------------
module slts_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  slts_pkg::t_div_req  i_req,
    output logic                o_done,
    output logic [63:0]         o_quot
);
    logic [63:0] r_quot, n_quot;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [32:0] w_shift;
    logic [32:0] w_sub;

    assign w_shift = {r_rem[31:0], r_quot[63]};
    assign w_sub   = w_shift - {1'b0, r_den};

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quot = i_req.num;
            n_rem  = '0;
            n_cnt  = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_sub[32]) begin
                n_rem  = w_sub;
                n_quot = {r_quot[62:0], 1'b1};
            end else begin
                n_rem  = w_shift;
                n_quot = {r_quot[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_req.start) r_den <= i_req.den;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

### rtl/slts_checker.sv
// ----------------------------------------------------------------------------
// slts_checker
// port-level checks of the sparse triangular solve core
// ----------------------------------------------------------------------------
`include "sparse_lower_triangular_solve_core_assert.svh"
module slts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        pready
);
    `SLTS_ASSERT_IMPL(a_no_accept_while_out, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `SLTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `SLTS_ASSERT_IMPL(a_pready, i_clk, i_rst_n, 1'b1, pready)
    `SLTS_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !m_axis_tvalid)
endmodule

bind sparse_lower_triangular_solve_core slts_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .pready(pready)
);

### sim/sparse_lower_triangular_solve_core_tb.sv
// ----------------------------------------------------------------------------
// sparse_lower_triangular_solve_core_tb
// self-checking bench for the sparse forward substitution core
// ----------------------------------------------------------------------------
// Nonzeros are streamed in row order with bursty valid, and the result side
// stalls on its own pattern, with one long hold-off. Every solved unknown is
// compared with a bit-exact Q16.16 predictor that mirrors the solver state.
// A short directed table comes first, then random matrices of varied sizes,
// with row_count changed over APB only while the core is idle.
module sparse_lower_triangular_solve_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles   = 200;

    // one nonzero as it travels on s_axis
    typedef struct packed {
        logic        start;
        logic        first;
        logic        last;
        logic [9:0]  col;
        logic [31:0] entry;
        logic [31:0] rhs;
    } t_nz;

    // one solved unknown as it travels on m_axis
    typedef struct packed {
        logic [9:0]  row;
        logic [31:0] sol;
        logic [1:0]  st;
    } t_sol;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sparse_lower_triangular_solve_core u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic signed [31:0] x_mem [slts_pkg::MaxRows];
    logic signed [31:0] acc_q;
    int unsigned        row_q;
    logic [1:0]         fault_q;
    int unsigned        row_count_q;
    logic [slts_pkg::MaxRows-1:0] x_written;

    t_sol expected_solutions[$];
    int   error_count = 0;
    int   idle_cycles = 0;
    bit   hold_off = 1'b0;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -66'sh80000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] div_round(input logic signed [31:0] a,
                                                      input logic signed [31:0] d);
        logic signed [65:0] num;
        logic [65:0]        n;
        logic [65:0]        m;
        logic [65:0]        q;
        logic               neg;
        num = 66'(a) <<< 16;
        neg = (num < 0) != (d < 0);
        n   = num < 0 ? -num : num;
        m   = d < 0 ? -66'(d) : 66'(d);
        q   = (n + (m >> 1)) / m;
        return sat32(neg ? -$signed(q) : $signed(q));
    endfunction

    function automatic void raise_fault(input logic [1:0] code);
        if (fault_q == slts_pkg::ST_OK) fault_q = code;
    endfunction

    // advance the solver state by one nonzero, queue a result on a diagonal
    function automatic void solve_nonzero(input t_nz nz);
        logic               ovf;
        logic signed [31:0] x;
        logic signed [65:0] diff;
        t_sol               res;
        x = '0;
        if (nz.start) row_q = 0;
        if (nz.start || nz.first) begin
            acc_q   = nz.rhs;
            fault_q = slts_pkg::ST_OK;
        end
        ovf = row_q >= (row_count_q > slts_pkg::MaxRows ? slts_pkg::MaxRows : row_count_q);
        if (ovf) raise_fault(slts_pkg::ST_OVERFLOW);
        if (!nz.last) begin
            if (!ovf) begin
                if (nz.col >= row_q) begin
                    raise_fault(slts_pkg::ST_COLUMN);
                end else begin
                    diff  = (66'(acc_q) <<< 16) - 66'($signed(nz.entry)) * 66'(x_mem[nz.col]);
                    acc_q = sat32((diff + 66'sd32768) >>> 16);
                end
            end
            return;
        end
        if (!ovf) begin
            if (nz.col != row_q) raise_fault(slts_pkg::ST_COLUMN);
            if (nz.entry == 0) begin
                raise_fault(slts_pkg::ST_ZERO);
                x = acc_q > 0 ? 32'sh7FFFFFFF : (acc_q < 0 ? 32'sh80000000 : 32'sd0);
            end else begin
                x = div_round(acc_q, nz.entry);
            end
            x_mem[row_q]     = x;
            x_written[row_q] = 1'b1;
        end
        res.row = row_q > 1023 ? 10'd1023 : 10'(row_q);
        res.sol = x;
        res.st  = fault_q;
        expected_solutions.insert(expected_solutions.size(), res);
        if (row_q < 2047) row_q++;
        acc_q   = '0;
        fault_q = slts_pkg::ST_OK;
    endfunction

    // result checker and receiver stall pattern
    always @(posedge i_clk) begin
        t_sol got;
        t_sol want;
        if (m_axis_tvalid && m_axis_tready) begin
            got.row = m_axis_tdata[9:0];
            got.sol = m_axis_tdata[41:10];
            got.st  = m_axis_tdata[43:42];
            if (expected_solutions.size() == 0) begin
                $error("unexpected result transaction row %0d", got.row);
                error_count++;
            end else begin
                want = expected_solutions.pop_front();
                if (got.row !== want.row) begin
                    $error("row_index expected %0d got %0d", want.row, got.row);
                    error_count++;
                end
                if (got.sol !== want.sol) begin
                    $error("solution_value expected %h got %h", want.sol, got.sol);
                    error_count++;
                end
                if (got.st !== want.st) begin
                    $error("status expected %0d got %0d", want.st, got.st);
                    error_count++;
                end
            end
        end
        if (hold_off) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 1);
    end

    // watchdog on accepted transactions
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("sparse_lower_triangular_solve_core verification failed");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop offering, wait until the core is idle, then write the limit
    task automatic set_row_count(input int unsigned value);
        s_axis_tvalid <= 1'b0;
        while (expected_solutions.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        apb_write(slts_pkg::ADDR_ROW_COUNT, 32'(value));
        row_count_q = value & 11'h7FF;
    endtask

    // offer one nonzero, random burst gaps, hold tvalid across items
    task automatic send_nonzero(input t_nz nz);
        if ($urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'd0, nz.rhs, nz.entry, nz.col, nz.last, nz.first, nz.start};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        solve_nonzero(nz);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h00010000 * $urandom_range(0, 4);
            3: return $urandom_range(0, 2) == 0 ? 32'h0 : 32'hFFFF0000;
            default: return $urandom;
        endcase
    endfunction

    // random matrix of n rows, mostly well formed, some noise
    task automatic send_matrix(input int unsigned n, input int unsigned noise);
        t_nz nz;
        int unsigned k;
        int unsigned c;
        for (int unsigned r = 0; r < n; r++) begin
            k = r == 0 ? 0 : $urandom_range(0, r < 4 ? r : 4);
            for (int unsigned j = 0; j <= k; j++) begin
                nz.start = (r == 0) && (j == 0);
                nz.first = (j == 0) && ($urandom_range(0, 9) != 0);
                nz.last  = j == k;
                nz.entry = rand_value();
                nz.rhs   = rand_value();
                c = nz.last ? r : $urandom_range(0, r - 1);
                if ($urandom_range(0, 99) < noise) c = $urandom_range(0, 1023);
                // never read an unknown that was never solved
                if (!nz.last && c < r && !x_written[c]) c = r;
                nz.col = c;
                send_nonzero(nz);
            end
        end
    endtask

    // directed stimulus table, known results where obvious
    typedef struct {
        t_nz  nz;
        bit   known;
        t_sol want;
    } t_row;

    t_row directed [16] = '{
        '{'{1'b1, 1'b1, 1'b1, 10'd0, 32'h00010000, 32'h00020000}, 1,
          '{10'd0, 32'h00020000, slts_pkg::ST_OK}},
        '{'{1'b0, 1'b1, 1'b0, 10'd0, 32'h00010000, 32'h00050000}, 0, '0},
        '{'{1'b0, 1'b0, 1'b1, 10'd1, 32'h00010000, 32'h0}, 1,
          '{10'd1, 32'h00030000, slts_pkg::ST_OK}},
        '{'{1'b0, 1'b1, 1'b1, 10'd2, 32'h00000000, 32'h7FFFFFFF}, 1,
          '{10'd2, 32'h7FFFFFFF, slts_pkg::ST_ZERO}},
        '{'{1'b0, 1'b1, 1'b1, 10'd3, 32'h00000000, 32'h80000000}, 1,
          '{10'd3, 32'h80000000, slts_pkg::ST_ZERO}},
        '{'{1'b0, 1'b1, 1'b1, 10'd4, 32'h00000000, 32'h0}, 1,
          '{10'd4, 32'h0, slts_pkg::ST_ZERO}},
        '{'{1'b0, 1'b1, 1'b0, 10'd9, 32'h00010000, 32'h00010000}, 0, '0},
        '{'{1'b0, 1'b0, 1'b1, 10'd0, 32'h00000000, 32'h0}, 1,
          '{10'd5, 32'h7FFFFFFF, slts_pkg::ST_COLUMN}},
        '{'{1'b0, 1'b1, 1'b0, 10'd2, 32'h7FFFFFFF, 32'h80000000}, 0, '0},
        '{'{1'b0, 1'b0, 1'b1, 10'd6, 32'h80000000, 32'h0}, 0, '0},
        '{'{1'b0, 1'b1, 1'b1, 10'd7, 32'h00000001, 32'h7FFFFFFF}, 0, '0},
        '{'{1'b0, 1'b1, 1'b1, 10'd8, 32'hFFFFFFFF, 32'h80000000}, 0, '0},
        '{'{1'b0, 1'b1, 1'b0, 10'd1, 32'hFFFF0000, 32'h00001234}, 0, '0},
        '{'{1'b0, 1'b0, 1'b0, 10'd3, 32'h12345678, 32'h0}, 0, '0},
        '{'{1'b0, 1'b0, 1'b1, 10'd9, 32'h00030000, 32'h0}, 0, '0},
        '{'{1'b0, 1'b0, 1'b1, 10'd10, 32'hFFFD0000, 32'h0}, 0, '0}
    };

    initial begin
        t_sol want;
        row_q       = 0;
        acc_q       = '0;
        fault_q     = slts_pkg::ST_OK;
        row_count_q = 1024;
        x_written   = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            send_nonzero(directed[i].nz);
            if (directed[i].known && directed[i].nz.last) begin
                want = expected_solutions[expected_solutions.size() - 1];
                if (want !== directed[i].want) begin
                    $error("table row %0d predictor disagrees with expected result", i);
                    error_count++;
                end
            end
        end

        // row overflow with a small limit, then a zero limit, then a limit of one with noise
        set_row_count(2);
        send_matrix(4, 0);
        set_row_count(0);
        send_matrix(2, 0);
        set_row_count(1);
        send_matrix(3, 10);

        // long receiver hold-off so the core fills up and stalls its input
        set_row_count(2047);
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            send_matrix(6, 0);
        join

        // random matrices, mostly small
        for (int i = 0; i < 50; i++) begin
            case ($urandom_range(0, 9))
                0: set_row_count($urandom_range(1, 8));
                1: set_row_count(1024);
                2: set_row_count($urandom_range(1025, 2047));
                default: ;
            endcase
            send_matrix($urandom_range(1, 8), $urandom_range(0, 1) ? 0 : 8);
        end

        // a longer matrix at the full row limit, with some noise
        set_row_count(1024);
        send_matrix(16, 3);

        // last row_count extreme and the drain
        set_row_count(2047);
        send_matrix(3, 0);
        s_axis_tvalid <= 1'b0;
        while (expected_solutions.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (error_count == 0)
            $display("sparse_lower_triangular_solve_core verification clean");
        else
            $display("sparse_lower_triangular_solve_core verification failed");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/slts_pkg.sv
rtl/slts_div.sv
rtl/sparse_lower_triangular_solve_core.sv
rtl/slts_checker.sv
sim/sparse_lower_triangular_solve_core_tb.sv
